FILE: rtl/core/frv_pkg.sv
// Shared types, codes and header layout constants for the frame receiver.
`timescale 1ns / 1ps

package frv_pkg;

	localparam int unsigned HDR_BYTES    = 20;
	localparam int unsigned TYPE_LIMIT   = 13;
	localparam int unsigned OFF_MAGIC    = 0;
	localparam int unsigned OFF_REVISION = 4;
	localparam int unsigned OFF_TYPE     = 6;
	localparam int unsigned OFF_FLAGS    = 8;
	localparam int unsigned OFF_RESERVED = 10;
	localparam int unsigned OFF_LENGTH   = 12;
	localparam int unsigned OFF_CRC      = 16;
	localparam int unsigned HDR_W        = HDR_BYTES * 8;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// event codes on the receive channel
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_PROTO = 3'd1;
	localparam logic [2:0] ST_CRC   = 3'd2;
	localparam logic [2:0] ST_TRUNC = 3'd3;
	localparam logic [2:0] ST_XPORT = 3'd4;

	// register indexes on the APB port
	localparam logic [1:0] REG_MAGIC    = 2'd0;
	localparam logic [1:0] REG_REVISION = 2'd1;
	localparam logic [1:0] REG_MAX_LEN  = 2'd2;

	typedef enum logic [0:0] {
		PH_HEADER  = 1'b0,
		PH_PAYLOAD = 1'b1
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
	} rx_beat_t;

	typedef struct packed {
		logic        has_byte;
		logic [7:0]  payload_byte;
		logic        last;
		logic [2:0]  status;
		logic [3:0]  msg_type;
		logic [15:0] frame_flags;
		logic [31:0] payload_length;
	} res_beat_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [15:0] revision;
		logic [31:0] max_len;
	} cfg_t;

	typedef struct packed {
		logic        good;
		logic [3:0]  msg_type;
		logic [15:0] flags;
		logic [31:0] length;
		logic [31:0] crc;
	} hdr_info_t;

endpackage

FILE: rtl/core/frv_rx_reg.sv
// Input register stage for receive beats.
`timescale 1ns / 1ps

module frv_rx_reg
	import frv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rx_valid,
	input  rx_beat_t rx_beat,
	output logic     rx_ready,
	input  logic     advance,
	output logic     valid_s1,
	output rx_beat_t beat_s1
);

	// the stage reloads whenever it is empty or its beat moves on this cycle
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			beat_s1 <= rx_beat;
		end
	end

endmodule

FILE: rtl/core/frv_hdr_check.sv
// Header field extraction and validity checks.
`timescale 1ns / 1ps

module frv_hdr_check
	import frv_pkg::*;
(
	input  logic [HDR_W-1:0] hdr,
	input  cfg_t             cfg,
	output hdr_info_t        info
);

	logic [31:0] magic;
	logic [15:0] revision;
	logic [15:0] ty;
	logic [15:0] reserved;

	always_comb begin
		magic    = hdr[OFF_MAGIC*8 +: 32];
		revision = hdr[OFF_REVISION*8 +: 16];
		ty       = hdr[OFF_TYPE*8 +: 16];
		reserved = hdr[OFF_RESERVED*8 +: 16];

		info.msg_type = ty[3:0];
		info.flags    = hdr[OFF_FLAGS*8 +: 16];
		info.length   = hdr[OFF_LENGTH*8 +: 32];
		info.crc      = hdr[OFF_CRC*8 +: 32];
		info.good     = (magic == cfg.magic)
			&& (revision == cfg.revision)
			&& (ty <= 16'(TYPE_LIMIT))
			&& (reserved == 16'd0)
			&& (info.length <= cfg.max_len);
	end

endmodule

FILE: rtl/core/frv_crc_byte.sv
// One-byte update of a reflected CRC-32C.
`timescale 1ns / 1ps

module frv_crc_byte
	import frv_pkg::*;
(
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	logic [31:0] c;

	always_comb begin
		c = crc_in ^ {24'd0, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		crc_out = c;
	end

endmodule

FILE: rtl/core/frame_receiver_validator_crc32c.sv
// Top level of the length-prefixed frame receiver with CRC-32C payload check.
`timescale 1ns / 1ps

// Usage
//   rx channel (rx_valid/rx_ready/rx_beat): one event per beat; kind is a data
//   byte, "no more data" or "stream closed". A 20-byte little-endian header is
//   collected and checked against the APB registers (magic, revision, max
//   payload length), the type limit and a zero reserved word.
//   res channel (res_valid/res_ready/res_beat): each payload byte comes out as
//   one beat; the last payload byte carries last=1 and ok/checksum status.
//   Header failures, truncation and transport errors give a single last beat.
// Timing
//   A beat taken in sits in the input stage and is processed from there into
//   the result register, which drives res_valid; a stall on res_ready holds
//   the beat in the input stage. One beat per cycle sustained while res_ready
//   stays high; the CRC byte update plus final compare in the payload path
//   sets the cycle time.
// Reset and stalls
//   arst_n clears the registers to magic 0, revision 0, max length all ones,
//   and puts the receiver back to waiting for a header. When res_ready is low
//   the result register holds; the input stage still takes one more beat, then
//   rx_ready drops until the result is taken.

module frame_receiver_validator_crc32c
	import frv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  rx_beat_t    rx_beat,
	output logic        res_valid,
	input  logic        res_ready,
	output res_beat_t   res_beat,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg_q;

	logic     valid_s1;
	rx_beat_t beat_s1;
	logic     advance;
	logic     fire;

	phase_t           phase_q, phase_d;
	logic [4:0]       hdr_cnt_q, hdr_cnt_d;
	logic [HDR_W-1:0] hdr_q, hdr_d;
	logic [31:0]      left_q, left_d;
	logic [31:0]      crc_q, crc_d;
	logic [3:0]       type_q, type_d;
	logic [15:0]      flags_q, flags_d;
	logic [31:0]      len_q, len_d;
	logic [31:0]      fcs_q, fcs_d;

	logic        emit;
	res_beat_t   res_d;
	logic        res_valid_q;
	res_beat_t   res_q;

	hdr_info_t   info;
	logic [31:0] crc_next;
	logic [31:0] left_dec;
	logic        in_pay;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic    <= 32'd0;
			cfg_q.revision <= 16'd0;
			cfg_q.max_len  <= 32'hFFFF_FFFF;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_MAGIC:    cfg_q.magic    <= pwdata;
				REG_REVISION: cfg_q.revision <= pwdata[15:0];
				REG_MAX_LEN:  cfg_q.max_len  <= pwdata;
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAGIC:    prdata = cfg_q.magic;
			REG_REVISION: prdata = {16'd0, cfg_q.revision};
			REG_MAX_LEN:  prdata = cfg_q.max_len;
			default:      prdata = 32'd0;
		endcase
	end

	// ---------------- input stage ----------------
	// the stage moves on whenever the result register is free or being drained
	assign advance = !res_valid_q || res_ready;
	assign fire    = valid_s1 && advance;

	frv_rx_reg u_rx_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_beat  (rx_beat),
		.rx_ready (rx_ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	// ---------------- datapath helpers ----------------
	// header as it stands once the current byte is shifted in
	assign hdr_d = {beat_s1.data_byte, hdr_q[HDR_W-1:8]};

	frv_hdr_check u_hdr_check (
		.hdr  (hdr_d),
		.cfg  (cfg_q),
		.info (info)
	);

	frv_crc_byte u_crc_byte (
		.crc_in  (crc_q),
		.data    (beat_s1.data_byte),
		.crc_out (crc_next)
	);

	assign left_dec = left_q - 32'd1;
	assign in_pay   = (phase_q == PH_PAYLOAD);

	// ---------------- next state and result ----------------
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		left_d    = left_q;
		crc_d     = crc_q;
		type_d    = type_q;
		flags_d   = flags_q;
		len_d     = len_q;
		fcs_d     = fcs_q;
		emit      = 1'b0;

		// header fields go out while a frame's payload is running or with an empty frame's result
		res_d.has_byte       = 1'b0;
		res_d.payload_byte   = 8'd0;
		res_d.last           = 1'b1;
		res_d.status         = ST_OK;
		res_d.msg_type       = in_pay ? type_q : 4'd0;
		res_d.frame_flags    = in_pay ? flags_q : 16'd0;
		res_d.payload_length = in_pay ? len_q : 32'd0;

		case (beat_s1.kind)
			KIND_CLOSE: begin
				emit         = 1'b1;
				res_d.status = ST_XPORT;
				phase_d      = PH_HEADER;
				hdr_cnt_d    = 5'd0;
				crc_d        = CRC_INIT;
			end
			KIND_END: begin
				emit         = 1'b1;
				// nothing received at all counts as a transport failure
				res_d.status = (!in_pay && hdr_cnt_q == 5'd0) ? ST_XPORT : ST_TRUNC;
				phase_d      = PH_HEADER;
				hdr_cnt_d    = 5'd0;
				crc_d        = CRC_INIT;
			end
			KIND_DATA: begin
				if (!in_pay) begin
					if (hdr_cnt_q == 5'(HDR_BYTES - 1)) begin
						hdr_cnt_d = 5'd0;
						if (!info.good) begin
							emit           = 1'b1;
							res_d.status   = ST_PROTO;
						end else if (info.length == 32'd0) begin
							// empty frame: header CRC must be zero
							emit                 = 1'b1;
							res_d.status         = (info.crc == 32'd0) ? ST_OK : ST_PROTO;
							res_d.msg_type       = info.msg_type;
							res_d.frame_flags    = info.flags;
							res_d.payload_length = info.length;
						end else begin
							phase_d = PH_PAYLOAD;
							left_d  = info.length;
							crc_d   = CRC_INIT;
							type_d  = info.msg_type;
							flags_d = info.flags;
							len_d   = info.length;
							fcs_d   = info.crc;
						end
					end else begin
						hdr_cnt_d = hdr_cnt_q + 5'd1;
					end
				end else begin
					emit               = 1'b1;
					res_d.has_byte     = 1'b1;
					res_d.payload_byte = beat_s1.data_byte;
					left_d             = left_dec;
					crc_d              = crc_next;
					if (left_dec != 32'd0) begin
						res_d.last = 1'b0;
					end else begin
						res_d.status = ((crc_next ^ CRC_INIT) == fcs_q) ? ST_OK : ST_CRC;
						phase_d      = PH_HEADER;
						hdr_cnt_d    = 5'd0;
						crc_d        = CRC_INIT;
					end
				end
			end
			default: ; // unused kind: dropped, no result
		endcase
	end

	// ---------------- state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 5'd0;
			crc_q     <= CRC_INIT;
			left_q    <= 32'd0;
		end else if (fire) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			crc_q     <= crc_d;
			left_q    <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			type_q  <= type_d;
			flags_q <= flags_d;
			len_q   <= len_d;
			fcs_q   <= fcs_d;
			if (beat_s1.kind == KIND_DATA && !in_pay) begin
				hdr_q <= hdr_d;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_q;

endmodule

FILE: test/frv_checker.sv
// Scoreboard for the frame receiver: CRC-32C helper package and the result checker.
`timescale 1ns / 1ps

package frv_tb_pkg;

	import frv_pkg::*;

	// one byte of reflected CRC-32C, no final inversion
	function automatic logic [31:0] crc32c_next(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

endpackage

module frv_checker
	import frv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_ready,
	input  rx_beat_t    rx_beat,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_beat_t   res_beat,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	import frv_tb_pkg::*;

	res_beat_t   due_results[$];
	res_beat_t   oldest;

	// receiver state as predicted
	phase_t      rx_phase;
	int          hdr_fill;
	logic [7:0]  hdr_bytes [HDR_BYTES];
	logic [31:0] pay_left;
	logic [31:0] pay_crc;
	logic [3:0]  f_type;
	logic [15:0] f_flags;
	logic [31:0] f_len;
	logic [31:0] f_crc;

	// register copies, taken from the APB writes
	logic [31:0] want_magic;
	logic [15:0] want_rev;
	logic [31:0] len_cap;

	int fails = 0;

	assign fail_count = fails;

	task automatic note_fail(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fails++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			note_fail($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic logic [15:0] hdr16(input int off);
		return {hdr_bytes[off + 1], hdr_bytes[off]};
	endfunction

	function automatic logic [31:0] hdr32(input int off);
		return {hdr16(off + 2), hdr16(off)};
	endfunction

	task automatic restart_frame();
		rx_phase = PH_HEADER;
		hdr_fill = 0;
		for (int i = 0; i < HDR_BYTES; i++)
			hdr_bytes[i] = '0;
		pay_left = '0;
		pay_crc = CRC_INIT;
		f_type = '0;
		f_flags = '0;
		f_len = '0;
		f_crc = '0;
	endtask

	task automatic queue_result(input logic hb, input logic [7:0] b, input logic fin,
		input logic [2:0] st, input logic keep);
		res_beat_t r;
		r = '0;
		r.has_byte = hb;
		r.payload_byte = b;
		r.last = fin;
		r.status = st;
		if (keep) begin
			r.msg_type = f_type;
			r.frame_flags = f_flags;
			r.payload_length = f_len;
		end
		due_results = {due_results, r};
	endtask

	task automatic advance_receiver(input rx_beat_t ev);
		logic [15:0] ty;
		logic [31:0] len;
		logic        good;
		case (ev.kind)
		KIND_CLOSE: begin
			queue_result(1'b0, 8'd0, 1'b1, ST_XPORT, rx_phase == PH_PAYLOAD);
			restart_frame();
		end
		KIND_END: begin
			queue_result(1'b0, 8'd0, 1'b1,
				(rx_phase == PH_HEADER && hdr_fill == 0) ? ST_XPORT : ST_TRUNC,
				rx_phase == PH_PAYLOAD);
			restart_frame();
		end
		KIND_DATA: begin
			if (rx_phase == PH_HEADER) begin
				hdr_bytes[hdr_fill] = ev.data_byte;
				hdr_fill++;
				if (hdr_fill == HDR_BYTES) begin
					ty = hdr16(OFF_TYPE);
					len = hdr32(OFF_LENGTH);
					good = hdr32(OFF_MAGIC) == want_magic && hdr16(OFF_REVISION) == want_rev
						&& ty <= TYPE_LIMIT && hdr16(OFF_RESERVED) == 16'd0 && len <= len_cap;
					if (!good) begin
						queue_result(1'b0, 8'd0, 1'b1, ST_PROTO, 1'b0);
						restart_frame();
					end else begin
						f_type = ty[3:0];
						f_flags = hdr16(OFF_FLAGS);
						f_len = len;
						f_crc = hdr32(OFF_CRC);
						if (len == 32'd0) begin
							// empty frame: header CRC must be zero
							queue_result(1'b0, 8'd0, 1'b1, (f_crc == 32'd0) ? ST_OK : ST_PROTO, 1'b1);
							restart_frame();
						end else begin
							rx_phase = PH_PAYLOAD;
							pay_left = len;
							pay_crc = CRC_INIT;
						end
					end
				end
			end else begin
				pay_crc = crc32c_next(pay_crc, ev.data_byte);
				pay_left = pay_left - 32'd1;
				if (pay_left != 32'd0) begin
					queue_result(1'b1, ev.data_byte, 1'b0, ST_OK, 1'b1);
				end else begin
					queue_result(1'b1, ev.data_byte, 1'b1,
						((pay_crc ^ CRC_INIT) == f_crc) ? ST_OK : ST_CRC, 1'b1);
					restart_frame();
				end
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			restart_frame();
			want_magic = '0;
			want_rev = '0;
			len_cap = '1;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
				REG_MAGIC:    want_magic = pwdata;
				REG_REVISION: want_rev = pwdata[15:0];
				REG_MAX_LEN:  len_cap = pwdata;
				default: ;
				endcase
			end
			if (rx_valid && rx_ready)
				advance_receiver(rx_beat);
			if (res_valid && res_ready) begin
				if (due_results.size() == 0) begin
					note_fail($sformatf("result %h with none pending", res_beat));
				end else begin
					oldest = due_results.pop_front();
					check_field("has_byte", 32'(res_beat.has_byte), 32'(oldest.has_byte));
					check_field("payload_byte", 32'(res_beat.payload_byte),
						32'(oldest.payload_byte));
					check_field("last", 32'(res_beat.last), 32'(oldest.last));
					check_field("status", 32'(res_beat.status), 32'(oldest.status));
					check_field("msg_type", 32'(res_beat.msg_type), 32'(oldest.msg_type));
					check_field("frame_flags", 32'(res_beat.frame_flags),
						32'(oldest.frame_flags));
					check_field("payload_length", res_beat.payload_length, oldest.payload_length);
				end
			end
			pending <= due_results.size();
		end
	end

endmodule

FILE: test/tb_frame_receiver_validator_crc32c.sv
// Testbench top for the frame receiver: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb_frame_receiver_validator_crc32c;

	import frv_pkg::*;
	import frv_tb_pkg::*;

	// kind code the block must ignore
	localparam logic [1:0]  KIND_UNUSED     = 2'd3;
	// slowest run stays well under this limit, leaving a wide margin
	localparam int unsigned CYCLE_LIMIT     = 600000;
	localparam int unsigned ITEMS_PER_PHASE = 270;
	// extra wait that lets beats left in the input stage and result register clear
	localparam int unsigned DRAIN_CYCLES    = 4;

	// header fields in reverse wire order: magic, the last member, is the lowest byte
	typedef struct packed {
		logic [31:0] len;
		logic [15:0] resv;
		logic [15:0] flags;
		logic [15:0] mtype;
		logic [15:0] rev;
		logic [31:0] magic;
	} frame_hdr_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	rx_beat_t    rx_beat = '0;
	logic        res_valid;
	logic        res_ready = 1'b1;
	res_beat_t   res_beat;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          pending;
	int unsigned cycles = 0;
	int          n_items = 0;
	int          stall_left = 0;
	bit          quiet = 1'b0;

	// register values as last written, used to build matching headers
	logic [31:0] cfg_magic = '0;
	logic [15:0] cfg_rev = '0;
	logic [31:0] cfg_max = '1;

	frame_receiver_validator_crc32c u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_beat  (rx_beat),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_beat (res_beat),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	frv_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_beat   (rx_beat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_beat  (res_beat),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side back-pressure: random stalls, none once quiet
	always @(posedge clk) begin
		if (quiet) begin
			res_ready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ready <= (stall_left == 1);
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 11);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// One beat on the rx channel. valid stays up after acceptance so a back-to-back
	// beat needs no second assignment in the same step; settle() drops it.
	task automatic push_event(input logic [1:0] k, input logic [7:0] b);
		rx_valid <= 1'b1;
		rx_beat <= {k, b};
		do @(posedge clk); while (!rx_ready);
		if (k != KIND_UNUSED)
			n_items++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Sender holds off until every predicted result is out, then lets the
	// pipeline empty of beats that produce nothing (header bytes, ignored kind).
	task automatic settle();
		rx_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup phase, then access until pready
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_MAGIC:    cfg_magic = val;
		REG_REVISION: cfg_rev = val[15:0];
		REG_MAX_LEN:  cfg_max = val;
		default: ;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] magic, input logic [15:0] rev,
		input logic [31:0] max_len);
		reg_write(REG_MAGIC, magic);
		reg_write(REG_REVISION, {16'd0, rev});
		reg_write(REG_MAX_LEN, max_len);
	endtask

	// header that passes every check under the current registers
	function automatic frame_hdr_t good_hdr(input logic [31:0] len);
		frame_hdr_t h;
		h.magic = cfg_magic;
		h.rev = cfg_rev;
		h.mtype = 16'($urandom_range(0, TYPE_LIMIT));
		h.flags = 16'($urandom);
		h.resv = '0;
		h.len = len;
		return h;
	endfunction

	// mostly short payloads; zero length now and then
	function automatic logic [31:0] pick_len();
		logic [31:0] cap;
		cap = (cfg_max < 40) ? cfg_max : 32'd40;
		if (cap == 0 || $urandom_range(0, 11) == 0)
			return 32'd0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(1, cap);
		return $urandom_range(1, (cap < 12) ? cap : 12);
	endfunction

	// Sends header plus n_pay random payload bytes. The header CRC is the real
	// payload CRC unless bad_crc. With cut_at >= 0 the stream stops after that
	// many data bytes and a cut_kind event follows.
	task automatic send_frame(input frame_hdr_t h, input int n_pay, input bit bad_crc,
		input int cut_at, input logic [1:0] cut_kind);
		logic [7:0]   pay_q[$];
		logic [7:0]   pb;
		logic [31:0]  crc;
		logic [159:0] hdr_bits;
		int           stop;
		crc = CRC_INIT;
		for (int i = 0; i < n_pay; i++) begin
			pb = 8'($urandom);
			pay_q = {pay_q, pb};
			crc = crc32c_next(crc, pb);
		end
		crc = crc ^ CRC_INIT;  // empty payload gives zero here
		if (bad_crc)
			crc = crc ^ ($urandom | 32'd1);
		hdr_bits = {crc, h};
		stop = (cut_at >= 0) ? cut_at : HDR_BYTES + n_pay;
		for (int i = 0; i < stop; i++) begin
			// stray ignored events sprinkled through the frame
			if ($urandom_range(0, 29) == 0)
				push_event(KIND_UNUSED, 8'($urandom));
			push_event(KIND_DATA, (i < HDR_BYTES) ? hdr_bits[8*i +: 8] : pay_q[i - HDR_BYTES]);
		end
		if (cut_at >= 0)
			push_event(cut_kind, 8'($urandom));
	endtask

	// Random traffic: mostly clean frames with random content, then header
	// faults, frames cut by end-of-data or close, and lone events.
	task automatic random_frame();
		frame_hdr_t h;
		int         sel;
		int         n_pay;
		int         cut;
		bit         bad_crc;
		logic [1:0] cut_kind;
		h = good_hdr(pick_len());
		n_pay = h.len;
		bad_crc = ($urandom_range(0, 9) == 0);
		cut = -1;
		cut_kind = ($urandom_range(0, 1) == 0) ? KIND_END : KIND_CLOSE;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			// clean frame
		end else if (sel < 80) begin
			n_pay = 0;  // rejected at the last header byte
			case ($urandom_range(0, 4))
			0: h.magic = h.magic ^ ($urandom | 32'd1);
			1: h.rev = h.rev ^ 16'($urandom | 32'd1);
			2: h.mtype = 16'($urandom_range(TYPE_LIMIT + 1, 16'hFFFF));
			3: h.resv = 16'($urandom | 32'd1);
			default: begin
				if (cfg_max != '1)
					h.len = cfg_max + 32'd1;
				else
					h.magic = ~h.magic;
			end
			endcase
		end else if (sel < 92) begin
			cut = $urandom_range(0, HDR_BYTES + n_pay - 1);
		end else begin
			case ($urandom_range(0, 2))
			0: push_event(KIND_END, 8'($urandom));
			1: push_event(KIND_CLOSE, 8'($urandom));
			default: push_event(KIND_UNUSED, 8'($urandom));
			endcase
			return;
		end
		send_frame(h, n_pay, bad_crc, cut, cut_kind);
	endtask

	initial begin : stimulus
		frame_hdr_t h;
		int         base;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: ordinary registers, small length cap ----
		set_regs(32'h1EDC_6F41, 16'h0003, 32'd64);

		push_event(KIND_END, 8'h00);        // end before any header byte
		push_event(KIND_CLOSE, 8'hFF);      // close while idle
		push_event(KIND_UNUSED, 8'hA5);     // ignored kind

		h = good_hdr(1);
		h.mtype = 16'(TYPE_LIMIT);
		h.flags = 16'hFFFF;
		send_frame(h, 1, 1'b0, -1, KIND_END);       // highest legal type, one byte
		h = good_hdr(3);
		h.mtype = '0;
		h.flags = '0;
		send_frame(h, 3, 1'b1, -1, KIND_END);       // checksum mismatch
		h = good_hdr(0);
		send_frame(h, 0, 1'b0, -1, KIND_END);       // empty frame, zero CRC
		send_frame(h, 0, 1'b1, -1, KIND_END);       // empty frame, nonzero CRC

		// header faults, one each
		h = good_hdr(4);
		h.magic = ~cfg_magic;
		send_frame(h, 0, 1'b0, -1, KIND_END);
		h = good_hdr(4);
		h.rev = ~cfg_rev;
		send_frame(h, 0, 1'b0, -1, KIND_END);
		h = good_hdr(4);
		h.mtype = 16'(TYPE_LIMIT + 1);
		send_frame(h, 0, 1'b0, -1, KIND_END);
		h = good_hdr(4);
		h.resv = 16'hFFFF;
		send_frame(h, 0, 1'b0, -1, KIND_END);
		h = good_hdr(cfg_max + 32'd1);
		send_frame(h, 0, 1'b0, -1, KIND_END);

		// cuts: mid-header and mid-payload, by end-of-data and by close
		h = good_hdr(5);
		send_frame(h, 5, 1'b0, 7, KIND_END);
		send_frame(h, 5, 1'b0, 22, KIND_END);
		send_frame(h, 5, 1'b0, 21, KIND_CLOSE);
		send_frame(h, 5, 1'b0, 19, KIND_CLOSE);

		// ---- all-ones registers; largest length, truncated after a few bytes ----
		settle();
		set_regs(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		h = good_hdr(32'hFFFF_FFFF);
		h.mtype = '0;
		h.flags = '0;
		send_frame(h, 3, 1'b0, 23, KIND_END);

		// ---- zero length cap: only empty frames get through ----
		settle();
		reg_write(REG_MAX_LEN, 32'd0);
		h = good_hdr(0);
		send_frame(h, 0, 1'b0, -1, KIND_END);
		h = good_hdr(1);
		send_frame(h, 0, 1'b0, -1, KIND_END);

		// ---- random phases, each under its own register setting ----
		base = n_items;
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
			0: set_regs($urandom, 16'($urandom), $urandom_range(8, 40));
			1: set_regs(32'd0, 16'd0, 32'hFFFF_FFFF);
			2: set_regs(32'hFFFF_FFFF, 16'hFFFF, $urandom_range(1, 20));
			default: begin
				set_regs($urandom, 16'($urandom), 32'd64);
				quiet = 1'b1;  // final stretch runs without gaps or stalls
			end
			endcase
			while (n_items < base + (ph + 1) * ITEMS_PER_PHASE)
				random_frame();
		end

		settle();
		repeat (6) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
